// ===== rtl/hcb_pkg.sv =====
// hcb_pkg: shared constants of the huffman code builder
// field widths of the input and result items; no dependencies
package hcb_pkg;

  localparam int unsigned InWeightW = 15;  // width of the weight field
  localparam int unsigned CodeW     = 15;  // width of the code_bits field
  localparam int unsigned LenW      = 4;   // width of the code_length field
  localparam int unsigned IdxW      = 4;   // width of the leaf_index field

endpackage

// ===== rtl/hcb_ram.sv =====
// hcb_ram: generic single write port, single read port ram
// read data registered; no dependencies
module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/hcb_min2.sv =====
// hcb_min2: shared selection unit, keeps the two smallest weights of a scan
// strict less-than, so the earlier index wins on a tie; no dependencies
module hcb_min2 #(
  parameter int unsigned NW = 19,
  parameter int unsigned NI = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          en_i,
  input  logic [NW-1:0] cand_w_i,
  input  logic [NI-1:0] cand_idx_i,
  output logic [NI-1:0] s1_o,
  output logic [NI-1:0] s2_o,
  output logic [NW-1:0] sum_o
);

  logic          f1_q, f2_q;
  logic [NW-1:0] w1_q, w2_q;
  logic [NI-1:0] s1_q, s2_q;
  logic          take1, take2;

  assign take1 = !f1_q || (cand_w_i < w1_q);
  assign take2 = !f2_q || (cand_w_i < w2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end else if (clear_i) begin
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end else if (en_i) begin
      priority if (take1) begin
        f2_q <= f1_q;
        f1_q <= 1'b1;
      end else if (take2) begin
        f2_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !clear_i) begin
      priority if (take1) begin
        w2_q <= w1_q;
        s2_q <= s1_q;
        w1_q <= cand_w_i;
        s1_q <= cand_idx_i;
      end else if (take2) begin
        w2_q <= cand_w_i;
        s2_q <= cand_idx_i;
      end
    end
  end

  assign s1_o  = s1_q;
  assign s2_o  = s2_q;
  assign sum_o = w1_q + w2_q;

endmodule

// ===== rtl/huffman_code_builder_unit.sv =====
// huffman_code_builder_unit: top level, sequencer, node flags and output register
// uses hcb_pkg, hcb_ram (node weights, parent links) and hcb_min2
//
// Input channel (in_valid_i / in_stall_o): one leaf weight per item, last_i
// closes the set. Non-final items are taken one per cycle while the block is
// idle. Leaves beyond MAX_LEAVES are dropped and every result of that set
// carries overflowed_o.
// On the closing item the block stalls its input and builds the tree with
// n-1 merges. Each merge scans nodes 0..top-1 through the weight ram, one node
// a cycle into the shared two-minimum unit, then writes the new node in the
// MERGE1 and MERGE2 states. Codes are then traced leaf to root through the
// parent ram, one level per TR_CHECK and TR_USE pass, and one result item is
// given per leaf in load order, the final one with last_leaf_o set.
// Output channel (out_valid_o / out_stall_i): results sit in an output
// register; while the receiver stalls, the trace waits. New leaves of the next
// set are taken while the last result still waits.
// Reset clears the leaf count, overflow flag, parent flags and the output
// valid; ram contents need no clearing as only entries written in a set are read.
module huffman_code_builder_unit #(
  parameter int unsigned MAX_LEAVES  = 16,
  parameter int unsigned WEIGHT_BITS = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hcb_pkg::InWeightW-1:0]   weight_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hcb_pkg::IdxW-1:0]        leaf_index_o,
  output logic [hcb_pkg::CodeW-1:0]       code_bits_o,
  output logic [hcb_pkg::LenW-1:0]        code_length_o,
  output logic                            overflowed_o,
  output logic                            last_leaf_o
);

  localparam int unsigned ND   = 2 * MAX_LEAVES - 1;
  localparam int unsigned NI   = $clog2(ND);
  localparam int unsigned LCW  = $clog2(MAX_LEAVES + 1);
  localparam int unsigned LIW  = $clog2(MAX_LEAVES);
  localparam int unsigned LENW = $clog2(MAX_LEAVES);
  localparam int unsigned WBE  = (WEIGHT_BITS < hcb_pkg::InWeightW) ?
                                 WEIGHT_BITS : hcb_pkg::InWeightW;
  localparam int unsigned NW   = WBE + $clog2(MAX_LEAVES);
  localparam int unsigned LENX = (LENW > hcb_pkg::LenW) ? LENW : hcb_pkg::LenW;
  localparam int unsigned LIX  = (LIW > hcb_pkg::IdxW) ? LIW : hcb_pkg::IdxW;

  typedef enum logic [2:0] {
    IDLE, PREP, SCAN, MERGE1, MERGE2, TR_CHECK, TR_USE, EMIT
  } state_e;

  state_e                   state_q;
  logic [LCW-1:0]           leaf_count_q;
  logic                     ovf_q;
  logic [ND-1:0]            has_parent_q;
  logic [NI-1:0]            top_q, j_q, rd_idx_q, c_q;
  logic [LCW-1:0]           mrem_q;
  logic                     rd_vld_q;
  logic [LIW-1:0]           i_q;
  logic [LENW-1:0]          len_q;
  logic [hcb_pkg::CodeW-1:0] code_q;
  logic                     out_valid_q;
  logic [hcb_pkg::IdxW-1:0]  leaf_index_q;
  logic [hcb_pkg::CodeW-1:0] code_bits_q;
  logic [hcb_pkg::LenW-1:0]  code_length_q;
  logic                     overflowed_q;
  logic                     last_leaf_q;

  logic                     in_acc, room, issue, out_free, is_last_leaf;
  logic [LENX-1:0]          len_x;
  logic [LIX-1:0]           idx_x;
  logic [NI-1:0]            s1, s2;
  logic [NW-1:0]            sum, w_rdata;
  logic [NI:0]              p_rdata;
  logic                     sel_clear, sel_en;
  logic                     w_we, p_we;
  logic [NI-1:0]            w_waddr, p_waddr;
  logic [NW-1:0]            w_wdata;
  logic [hcb_pkg::InWeightW-1:0] wmask;

  assign wmask        = (WEIGHT_BITS >= hcb_pkg::InWeightW) ? '1 :
                        hcb_pkg::InWeightW'((1 << WBE) - 1);
  assign in_stall_o   = (state_q != IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign room         = (leaf_count_q < LCW'(MAX_LEAVES));
  assign issue        = (j_q < top_q);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign is_last_leaf = ((LCW'(i_q) + LCW'(1)) == leaf_count_q);
  assign len_x        = LENX'(len_q);
  assign idx_x        = LIX'(i_q);

  // node weights: leaves on load, internal nodes on merge
  assign w_we    = (in_acc && room) || (state_q == MERGE1);
  assign w_waddr = (state_q == MERGE1) ? top_q : NI'(leaf_count_q);
  assign w_wdata = (state_q == MERGE1) ? sum : NW'(weight_i & wmask);

  // parent links carry a side bit: set when the node is the right child
  assign p_we    = (state_q == MERGE1) || (state_q == MERGE2);
  assign p_waddr = (state_q == MERGE1) ? s1 : s2;

  assign sel_clear = (state_q == PREP) || (state_q == MERGE2);
  assign sel_en    = (state_q == SCAN) && rd_vld_q && !has_parent_q[rd_idx_q];

  hcb_ram #(.WIDTH(NW), .DEPTH(ND)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (j_q),
    .rdata_o (w_rdata)
  );

  hcb_ram #(.WIDTH(NI + 1), .DEPTH(ND)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i ({(state_q == MERGE2), top_q}),
    .raddr_i (c_q),
    .rdata_o (p_rdata)
  );

  hcb_min2 #(.NW(NW), .NI(NI)) u_min2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (sel_clear),
    .en_i       (sel_en),
    .cand_w_i   (w_rdata),
    .cand_idx_i (rd_idx_q),
    .s1_o       (s1),
    .s2_o       (s2),
    .sum_o      (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= IDLE;
      leaf_count_q  <= '0;
      ovf_q         <= 1'b0;
      has_parent_q  <= '0;
      top_q         <= '0;
      j_q           <= '0;
      rd_idx_q      <= '0;
      rd_vld_q      <= 1'b0;
      c_q           <= '0;
      mrem_q        <= '0;
      i_q           <= '0;
      len_q         <= '0;
      code_q        <= '0;
      out_valid_q   <= 1'b0;
      leaf_index_q  <= '0;
      code_bits_q   <= '0;
      code_length_q <= '0;
      overflowed_q  <= 1'b0;
      last_leaf_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_acc) begin
            if (room) begin
              leaf_count_q <= leaf_count_q + LCW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              state_q <= PREP;
            end
          end
        end
        PREP: begin
          top_q  <= NI'(leaf_count_q);
          mrem_q <= leaf_count_q - LCW'(1);
          j_q    <= '0;
          rd_vld_q <= 1'b0;
          i_q    <= '0;
          c_q    <= '0;
          len_q  <= '0;
          code_q <= '0;
          // single leaf: no merge, straight to the trace
          state_q <= (leaf_count_q == LCW'(1)) ? TR_CHECK : SCAN;
        end
        SCAN: begin
          if (issue) begin
            j_q <= j_q + NI'(1);
          end
          rd_vld_q <= issue;
          rd_idx_q <= j_q;
          if (!issue && !rd_vld_q) begin
            state_q <= MERGE1;
          end
        end
        MERGE1: begin
          has_parent_q[s1]    <= 1'b1;
          has_parent_q[s2]    <= 1'b1;
          has_parent_q[top_q] <= 1'b0;
          state_q <= MERGE2;
        end
        MERGE2: begin
          top_q  <= top_q + NI'(1);
          mrem_q <= mrem_q - LCW'(1);
          j_q    <= '0;
          state_q <= (mrem_q == LCW'(1)) ? TR_CHECK : SCAN;
        end
        TR_CHECK: begin
          state_q <= has_parent_q[c_q] ? TR_USE : EMIT;
        end
        TR_USE: begin
          if (p_rdata[NI] && (len_x < LENX'(hcb_pkg::CodeW))) begin
            code_q[len_x[hcb_pkg::LenW-1:0]] <= 1'b1;
          end
          len_q   <= len_q + LENW'(1);
          c_q     <= p_rdata[NI-1:0];
          state_q <= TR_CHECK;
        end
        EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            leaf_index_q  <= idx_x[hcb_pkg::IdxW-1:0];
            code_bits_q   <= code_q;
            code_length_q <= len_x[hcb_pkg::LenW-1:0];
            overflowed_q  <= ovf_q;
            last_leaf_q   <= is_last_leaf;
            if (is_last_leaf) begin
              has_parent_q <= '0;
              leaf_count_q <= '0;
              ovf_q        <= 1'b0;
              state_q      <= IDLE;
            end else begin
              i_q     <= i_q + LIW'(1);
              c_q     <= NI'(i_q) + NI'(1);
              len_q   <= '0;
              code_q  <= '0;
              state_q <= TR_CHECK;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign leaf_index_o  = leaf_index_q;
  assign code_bits_o   = code_bits_q;
  assign code_length_o = code_length_q;
  assign overflowed_o  = overflowed_q;
  assign last_leaf_o   = last_leaf_q;

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after closing item");

  a_distinct_children: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MERGE1 |-> s1 != s2)
    else $error("merge picked the same node twice");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_count_q <= LCW'(MAX_LEAVES))
    else $error("leaf count beyond capacity");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == IDLE |-> has_parent_q == '0)
    else $error("parent flags left set between sets");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for huffman_code_builder_unit
// uses hcb_pkg for field widths; holds its own tree builder as the predictor
// leaf sets of varied size and weight spread, with random idling on both sides
module tb_top;

  localparam int unsigned InWeightW     = hcb_pkg::InWeightW;
  localparam int unsigned CodeW         = hcb_pkg::CodeW;
  localparam int unsigned LenW          = hcb_pkg::LenW;
  localparam int unsigned IdxW          = hcb_pkg::IdxW;
  localparam int unsigned MaxLeaves     = 16;
  localparam int unsigned NodeDepth     = 2 * MaxLeaves - 1;
  localparam logic [InWeightW-1:0] WeightMax = '1;
  localparam int unsigned RandomItems   = 320;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned CycleLimit    = 400000;

  typedef struct packed {
    logic [IdxW-1:0]  leaf_index;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
    logic             overflowed;
    logic             last_leaf;
  } leaf_code_t;

  // builds the tree for each closed set and keeps the codes still to arrive
  class code_table_checker;
    logic [19:0] node_weight [NodeDepth];
    logic [4:0]  node_up     [NodeDepth];
    logic [4:0]  node_left   [NodeDepth];
    bit          node_linked [NodeDepth];
    int unsigned leaves_held = 0;
    bit          dropped     = 1'b0;
    leaf_code_t  pending_codes[$];
    int unsigned failures    = 0;

    function void note_leaf(logic [InWeightW-1:0] w, logic closing);
      int unsigned n, top, s1, s2, c, p, len;
      logic [19:0] w1, w2;
      bit f1, f2;
      logic [CodeW-1:0] code;
      leaf_code_t item;
      if (leaves_held < MaxLeaves) begin
        node_weight[leaves_held] = 20'(w);
        node_linked[leaves_held] = 1'b0;
        leaves_held++;
      end else begin
        dropped = 1'b1;
      end
      if (!closing) return;
      n = leaves_held;
      for (int unsigned m = 0; m + 1 < n; m++) begin
        top = n + m;
        f1 = 1'b0; f2 = 1'b0; s1 = 0; s2 = 0; w1 = '0; w2 = '0;
        // strict less-than so the earlier node wins a tie
        for (int unsigned j = 0; j < top; j++) begin
          if (node_linked[j]) continue;
          if (!f1 || node_weight[j] < w1) begin
            w2 = w1; s2 = s1; f2 = f1;
            w1 = node_weight[j]; s1 = j; f1 = 1'b1;
          end else if (!f2 || node_weight[j] < w2) begin
            w2 = node_weight[j]; s2 = j; f2 = 1'b1;
          end
        end
        node_up[s1] = top[4:0];
        node_up[s2] = top[4:0];
        node_linked[s1] = 1'b1;
        node_linked[s2] = 1'b1;
        node_weight[top] = w1 + w2;
        node_left[top] = s1[4:0];
        node_linked[top] = 1'b0;
      end
      for (int unsigned i = 0; i < n; i++) begin
        code = '0;
        len = 0;
        c = i;
        // walk leaf to root, so the root bit ends up most significant
        while (node_linked[c]) begin
          p = 32'(node_up[c]);
          if (node_left[p] != c[4:0]) code |= CodeW'(1) << len;
          len++;
          c = p;
        end
        item.leaf_index  = i[IdxW-1:0];
        item.code_bits   = code;
        item.code_length = len[LenW-1:0];
        item.overflowed  = dropped;
        item.last_leaf   = (i + 1 == n);
        pending_codes.push_back(item);
      end
      for (int unsigned k = 0; k < NodeDepth; k++) node_linked[k] = 1'b0;
      leaves_held = 0;
      dropped = 1'b0;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_code(leaf_code_t got);
      leaf_code_t want;
      if (pending_codes.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual leaf %0d code %0h len %0d",
                 $time, got.leaf_index, got.code_bits, got.code_length);
        return;
      end
      want = pending_codes.pop_front();
      compare_field("leaf_index", 32'(want.leaf_index), 32'(got.leaf_index));
      compare_field("code_bits", 32'(want.code_bits), 32'(got.code_bits));
      compare_field("code_length", 32'(want.code_length), 32'(got.code_length));
      compare_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
      compare_field("last_leaf", 32'(want.last_leaf), 32'(got.last_leaf));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [InWeightW-1:0] weight_i    = '0;
  logic                 last_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [IdxW-1:0]      leaf_index_o;
  logic [CodeW-1:0]     code_bits_o;
  logic [LenW-1:0]      code_length_o;
  logic                 overflowed_o;
  logic                 last_leaf_o;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 70;
  bit          hold_off_req  = 1'b0;
  int unsigned cycle_count   = 0;

  code_table_checker code_book = new();

  huffman_code_builder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .weight_i      (weight_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .leaf_index_o  (leaf_index_o),
    .code_bits_o   (code_bits_o),
    .code_length_o (code_length_o),
    .overflowed_o  (overflowed_o),
    .last_leaf_o   (last_leaf_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      code_book.check_code('{leaf_index_o, code_bits_o, code_length_o,
                             overflowed_o, last_leaf_o});
    end
  end

  // receiver side; a hold-off request keeps stall high for a long stretch
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_leaf(input logic [InWeightW-1:0] w, input logic closing);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    weight_i   <= w;
    last_i     <= closing;
    do @(posedge clk_i); while (in_stall_o);
    code_book.note_leaf(w, closing);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned items_sent, set_size, spread, pick;
    logic [InWeightW-1:0] w;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single leaf at both weight extremes
    send_leaf('0, 1'b1);
    send_leaf(WeightMax, 1'b1);
    // two leaves, largest weight first
    send_leaf(WeightMax, 1'b0);
    send_leaf('0, 1'b1);
    // equal weights resolve to the earlier node
    repeat (3) send_leaf(15'd5, 1'b0);
    send_leaf(15'd5, 1'b1);
    // full set of 0x2aaa and largest weights plus a dropped closing leaf
    for (int unsigned i = 0; i < MaxLeaves; i++)
      send_leaf((i % 3 == 0) ? 15'h2aaa : WeightMax, 1'b0);
    send_leaf(15'h5555, 1'b1);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      if (items_sent < RandomItems / 3) begin
        send_idle_pct = 12; recv_idle_pct = 70;
      end else if (items_sent < 2 * RandomItems / 3) begin
        send_idle_pct = 70; recv_idle_pct = 12;
      end else begin
        if (send_idle_pct != 0) hold_off_req = 1'b1;
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 8)       set_size = $urandom_range(MaxLeaves + 3, MaxLeaves + 1);
      else if (pick < 20) set_size = $urandom_range(2, 1);
      else                set_size = $urandom_range(MaxLeaves, 3);
      spread = $urandom_range(3);
      for (int unsigned i = 0; i < set_size; i++) begin
        case (spread)
          0: w = InWeightW'($urandom);
          1: w = InWeightW'($urandom_range(3));
          2: w = ($urandom_range(1) != 0) ? WeightMax : InWeightW'($urandom_range(1));
          default: w = InWeightW'(1) << $urandom_range(InWeightW - 1);
        endcase
        send_leaf(w, i + 1 == set_size);
      end
      items_sent += set_size;
    end
    in_valid_i <= 1'b0;

    while (code_book.pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (code_book.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hcb_pkg.sv
rtl/hcb_ram.sv
rtl/hcb_min2.sv
rtl/huffman_code_builder_unit.sv
tb/tb_top.sv
